[hw/rtl/stbg_pkg.sv]
// Shared constants, beat types and the sine table generator of the tone burst generator.
package stbg_pkg;

   // Audio and table geometry.
   localparam int AUDIO_RATE_HZ   = 44100;
   localparam int TABLE_SIZE      = 256;
   localparam int TABLE_W         = $clog2(TABLE_SIZE);
   localparam int PHASE_FRAC_BITS = 16;
   localparam int PHASE_W         = TABLE_W + PHASE_FRAC_BITS;
   localparam int GAP_SAMPLES     = 256;

   // Field and counter widths.
   localparam int FREQ_W     = 16;
   localparam int MS_W       = 16;
   localparam int SAMPLE_W   = 15;
   localparam int SAMPLES_W  = 23;
   localparam int GAP_W      = 9;

   // Amplitudes. The quiet level 10000/16000 reduces to 5/8.
   localparam int AMP_FULL    = 16000;
   localparam int AMP_QUIET   = 10000;
   localparam int QUIET_NUM   = 5;
   localparam int QUIET_SHIFT = 3;
   localparam int MS_PER_SEC  = 1000;

   // Sample count: floor(AUDIO_RATE_HZ * ms / 1000) as a multiply by a rounded-up reciprocal.
   // With 2^shift >= 2^16 * divisor the result is exact for every 16-bit operand.
   localparam int COUNT_SHIFT = MS_W + $clog2(MS_PER_SEC);
   localparam longint unsigned COUNT_MUL =
      ((longint'(AUDIO_RATE_HZ) << COUNT_SHIFT) + longint'(MS_PER_SEC) - 1) / MS_PER_SEC;
   localparam int COUNT_PROD_W = COUNT_SHIFT + SAMPLES_W;

   // Phase step: floor(freq * TABLE_SIZE * 2^PHASE_FRAC_BITS / AUDIO_RATE_HZ), wrapped.
   localparam int STEP_SHIFT = FREQ_W + $clog2(AUDIO_RATE_HZ);
   localparam longint unsigned STEP_MUL =
      ((longint'(TABLE_SIZE) << (PHASE_FRAC_BITS + STEP_SHIFT)) + longint'(AUDIO_RATE_HZ) - 1)
      / AUDIO_RATE_HZ;
   localparam int STEP_PROD_W = STEP_SHIFT + PHASE_W;

   // Sine generation in Q30.
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int TAYLOR_TERMS = 9;

   // Rounded-up reciprocals of the Taylor divisors (2n)(2n+1). Every dividend stays
   // below 2^32, so a shift of 42 gives an exact floor.
   localparam int TAYLOR_SHIFT = 42;
   localparam longint unsigned TAYLOR_ONE = 64'd1 << TAYLOR_SHIFT;
   localparam logic [TAYLOR_TERMS-1:0][63:0] TAYLOR_RECIP = {
      (TAYLOR_ONE + 64'd341) / 64'd342,
      (TAYLOR_ONE + 64'd271) / 64'd272,
      (TAYLOR_ONE + 64'd209) / 64'd210,
      (TAYLOR_ONE + 64'd155) / 64'd156,
      (TAYLOR_ONE + 64'd109) / 64'd110,
      (TAYLOR_ONE + 64'd71) / 64'd72,
      (TAYLOR_ONE + 64'd41) / 64'd42,
      (TAYLOR_ONE + 64'd19) / 64'd20,
      (TAYLOR_ONE + 64'd5) / 64'd6
   };

   // Request beat.
   typedef struct packed {
      logic              command;
      logic [FREQ_W-1:0] freq_hz;
      logic [MS_W-1:0]   burst_ms;
      logic              quiet;
   } stbg_item_type;

   // Response beat.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       busy_res;
      logic                       load_accepted;
   } stbg_result_type;

   // One sine table entry: AMP_FULL * sin(2*pi*idx/TABLE_SIZE), truncated toward zero.
   // Evaluated only at elaboration.
   function automatic int sine_entry(int idx);
      longint unsigned quad;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned mag;
      longint          sum;
      logic [127:0]    prod;
      int              n;
      quad = (longint'(idx) * 4) >> TABLE_W;
      r    = longint'(idx) * 4 - quad * TABLE_SIZE;
      if (quad[0]) begin
         r = longint'(TABLE_SIZE) - r;
      end
      if (r == longint'(TABLE_SIZE)) begin
         mag = longint'(AMP_FULL);
      end else begin
         x    = (HALF_PI_Q30 * r) >> TABLE_W;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (n = 1; n <= TAYLOR_TERMS; n++) begin
            prod = 128'((term * x2) >> 30) * 128'(TAYLOR_RECIP[n-1]);
            term = 64'(prod >> TAYLOR_SHIFT);
            if (n[0]) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         mag = (longint'(sum) * longint'(AMP_FULL) + 64'd1024) >> 30;
         if (mag > longint'(AMP_FULL)) begin
            mag = longint'(AMP_FULL);
         end
      end
      return (quad >= 2) ? -int'(mag) : int'(mag);
   endfunction

endpackage

[hw/rtl/stbg_sine_rom.sv]
// Constant sine table with the amplitude scaling of a tone sample.
module stbg_sine_rom (
   input  logic [stbg_pkg::TABLE_W-1:0]         index,
   input  logic                                 quiet,
   output logic signed [stbg_pkg::SAMPLE_W-1:0] sample
);

   localparam int SCALE_W = stbg_pkg::SAMPLE_W + stbg_pkg::QUIET_SHIFT;

   logic signed [stbg_pkg::SAMPLE_W-1:0] rom [stbg_pkg::TABLE_SIZE];
   logic signed [stbg_pkg::SAMPLE_W-1:0] entry;
   logic [stbg_pkg::SAMPLE_W-1:0]        mag;
   logic [SCALE_W-1:0]                   scaled;
   logic [stbg_pkg::SAMPLE_W-1:0]        mag_out;

   // Table contents are fixed at elaboration.
   for (genvar gi = 0; gi < stbg_pkg::TABLE_SIZE; gi++) begin : g_rom
      localparam int Entry = stbg_pkg::sine_entry(gi);
      assign rom[gi] = stbg_pkg::SAMPLE_W'(Entry);
   end

   // Scale the magnitude so the division truncates toward zero, then restore the sign.
   always_comb begin
      entry  = rom[index];
      mag    = entry[stbg_pkg::SAMPLE_W-1] ? -entry : entry;
      scaled = (SCALE_W'(mag) * SCALE_W'(stbg_pkg::QUIET_NUM)) >> stbg_pkg::QUIET_SHIFT;
      mag_out = quiet ? scaled[stbg_pkg::SAMPLE_W-1:0] : mag;
      sample  = entry[stbg_pkg::SAMPLE_W-1] ? -mag_out : mag_out;
   end

endmodule

[hw/rtl/stbg_core.sv]
// Play state, phase accumulator and per-beat result logic of the tone burst generator.
module stbg_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  stbg_pkg::stbg_item_type   item,
   input  logic                      muted,
   output stbg_pkg::stbg_result_type result
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_TONE,
      MODE_SILENCE,
      MODE_GAP
   } mode_type;

   mode_type                          mode_ff, mode_in;
   logic [stbg_pkg::PHASE_W-1:0]      phase_acc_ff, phase_acc_in;
   logic [stbg_pkg::PHASE_W-1:0]      phase_step_ff, phase_step_in;
   logic [stbg_pkg::SAMPLES_W-1:0]    samples_left_ff, samples_left_in;
   logic [stbg_pkg::GAP_W-1:0]        gap_left_ff, gap_left_in;
   logic                              quiet_sel_ff, quiet_sel_in;

   logic [stbg_pkg::COUNT_PROD_W-1:0] count_prod;
   logic [stbg_pkg::SAMPLES_W-1:0]    count;
   logic [stbg_pkg::STEP_PROD_W-1:0]  step_prod;
   logic [stbg_pkg::PHASE_W-1:0]      step;
   logic signed [stbg_pkg::SAMPLE_W-1:0] tone_sample;

   // Table read at the integer part of the phase.
   stbg_sine_rom u_rom (
      .index  (phase_acc_ff[stbg_pkg::PHASE_W-1:stbg_pkg::PHASE_FRAC_BITS]),
      .quiet  (quiet_sel_ff),
      .sample (tone_sample)
   );

   // Load arithmetic: sample count and phase step by reciprocal multiplication.
   always_comb begin
      count_prod = stbg_pkg::COUNT_PROD_W'(item.burst_ms)
                 * stbg_pkg::COUNT_PROD_W'(stbg_pkg::COUNT_MUL);
      count      = count_prod[stbg_pkg::COUNT_PROD_W-1 -: stbg_pkg::SAMPLES_W];
      step_prod  = stbg_pkg::STEP_PROD_W'(item.freq_hz)
                 * stbg_pkg::STEP_PROD_W'(stbg_pkg::STEP_MUL);
      step       = step_prod[stbg_pkg::STEP_PROD_W-1 -: stbg_pkg::PHASE_W];
   end

   // Next state and the result of the current beat.
   always_comb begin
      mode_in         = mode_ff;
      phase_acc_in    = phase_acc_ff;
      phase_step_in   = phase_step_ff;
      samples_left_in = samples_left_ff;
      gap_left_in     = gap_left_ff;
      quiet_sel_in    = quiet_sel_ff;
      result.sample        = '0;
      result.load_accepted = 1'b0;

      if (item.command) begin
         // A load is taken only when idle and not muted; a zero count starts nothing.
         if (mode_ff == MODE_IDLE && !muted) begin
            result.load_accepted = 1'b1;
            if (count != '0) begin
               samples_left_in = count;
               if (item.freq_hz == '0) begin
                  mode_in = MODE_SILENCE;
               end else begin
                  mode_in       = MODE_TONE;
                  quiet_sel_in  = item.quiet;
                  phase_acc_in  = '0;
                  phase_step_in = step;
               end
            end
         end
      end else begin
         case (mode_ff)
            MODE_TONE: begin
               result.sample   = tone_sample;
               phase_acc_in    = phase_acc_ff + phase_step_ff;
               samples_left_in = samples_left_ff - 1'b1;
               // The last tone sample enters the gap in the same tick.
               if (samples_left_ff == stbg_pkg::SAMPLES_W'(1)) begin
                  gap_left_in = stbg_pkg::GAP_W'(stbg_pkg::GAP_SAMPLES);
                  mode_in     = (stbg_pkg::GAP_SAMPLES != 0) ? MODE_GAP : MODE_IDLE;
               end
            end
            MODE_SILENCE: begin
               samples_left_in = samples_left_ff - 1'b1;
               if (samples_left_ff == stbg_pkg::SAMPLES_W'(1)) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_GAP: begin
               gap_left_in = gap_left_ff - 1'b1;
               if (gap_left_ff == stbg_pkg::GAP_W'(1)) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end

      result.busy_res = (mode_in != MODE_IDLE);
   end

   // State advances only when a beat moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else if (fire) begin
         mode_ff <= mode_in;
      end
      if (fire) begin
         phase_acc_ff    <= phase_acc_in;
         phase_step_ff   <= phase_step_in;
         samples_left_ff <= samples_left_in;
         gap_left_ff     <= gap_left_in;
         quiet_sel_ff    <= quiet_sel_in;
      end
   end

endmodule

[hw/rtl/sine_tone_burst_generator.sv]
// Top level of the sine tone burst generator: request register, result register and control.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    command, freq_hz, burst_ms, quiet
//   rsp_      out        rsp_valid/rsp_ready    sample, busy_res, load_accepted
//   csr_      in         csr_write_en           csr_write_data (muted)
//
// One beat per cycle sustained while rsp_ does not stall; a request beat is taken into the request
// register, and its result moves on into the result register, from which rsp_ presents it.
// The path from the request register to the result register holds the table read and the
// two constant multipliers of a load.
// Reset is synchronous; it empties both registers and returns the player to idle, unmuted.
// A stall on rsp_ holds the result register; req_ready stays high while the request
// register can still move on.
module sine_tone_burst_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [stbg_pkg::FREQ_W-1:0]          req_freq_hz,
   input  logic [stbg_pkg::MS_W-1:0]            req_burst_ms,
   input  logic                                 req_quiet,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [stbg_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_load_accepted,
   input  logic                                 csr_write_en,
   input  logic                                 csr_write_data
);

   stbg_pkg::stbg_item_type   item_ff;
   stbg_pkg::stbg_result_type res_ff;
   stbg_pkg::stbg_result_type core_res;
   logic                      in_valid_ff, in_valid_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      muted_ff;
   logic                      out_free;
   logic                      advance;

   // Handshake: a beat leaves the request register when the result register is free.
   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      advance      = in_valid_ff && out_free;
      req_ready    = !in_valid_ff || advance;
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
   end

   stbg_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .muted  (muted_ff),
      .result (core_res)
   );

   // Control registers and the mute register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         muted_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_en) begin
            muted_ff <= csr_write_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.command  <= req_command;
         item_ff.freq_hz  <= req_freq_hz;
         item_ff.burst_ms <= req_burst_ms;
         item_ff.quiet    <= req_quiet;
      end
      if (advance) begin
         res_ff <= core_res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sample        = res_ff.sample;
   assign rsp_busy_res      = res_ff.busy_res;
   assign rsp_load_accepted = res_ff.load_accepted;

endmodule

[hw/rtl/stbg_checker.sv]
// Port-level checks of the sine tone burst generator and their binding to the top level.
module stbg_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [stbg_pkg::SAMPLE_W-1:0] rsp_sample,
   input logic                                 rsp_busy_res,
   input logic                                 rsp_load_accepted
);

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample)
         && $stable(rsp_busy_res) && $stable(rsp_load_accepted))
      else $error("stalled response beat changed");

   // A taken load produces no audio.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_accepted |-> rsp_sample == '0)
      else $error("load beat carries a nonzero sample");

   // Samples stay within the full-scale amplitude.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample >= -stbg_pkg::AMP_FULL && rsp_sample <= stbg_pkg::AMP_FULL)
      else $error("sample out of range");

   // Audio only comes from a tone, which is always followed by a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample != '0 && stbg_pkg::GAP_SAMPLES != 0 |-> rsp_busy_res)
      else $error("tone sample reported as idle");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sine_tone_burst_generator stbg_checker u_stbg_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_sample        (rsp_sample),
   .rsp_busy_res      (rsp_busy_res),
   .rsp_load_accepted (rsp_load_accepted)
);

[dv/sine_tone_burst_generator_tb.sv]
// Self-checking testbench for the sine tone burst generator: stimulus, predictor and scoreboard.
`timescale 1ns / 1ps

module sine_tone_burst_generator_tb;

   // Behavior constants of the tone generator, kept independent of the design.
   localparam int RATE_HZ    = 44100;
   localparam int LUT_SIZE   = 256;
   localparam int FRAC_BITS  = 16;
   localparam int GAP_LEN    = 256;
   localparam int SINE_PEAK  = 16000;
   localparam int QUIET_AMP  = 10000;
   localparam int MS_PER_S   = 1000;
   localparam int DRAIN_SLACK = 8;
   localparam int MAX_PRINTS  = 30;

   // Request opcodes.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   typedef longint unsigned u64_type;
   typedef enum logic [1:0] {PLAY_IDLE, PLAY_TONE, PLAY_SILENCE, PLAY_GAP} play_mode_type;

   // Random phases: sender idle and receiver stall percentages, mute setting, beat count.
   localparam int N_PHASES = 5;
   int phase_send_idle[N_PHASES]  = '{0, 82, 0, 0, 16};
   int phase_recv_stall[N_PHASES] = '{0, 0, 82, 82, 16};
   bit phase_muted[N_PHASES]      = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
   int phase_items[N_PHASES]      = '{140, 100, 60, 100, 100};

   // Predicts every response beat and compares it with what the design returns.
   class tone_predictor;
      int                        sine_lut[LUT_SIZE];
      stbg_pkg::stbg_result_type predicted_beats[$];
      bit                        muted;
      u64_type                   phase_acc;
      u64_type                   phase_step;
      int unsigned               samples_left;
      int unsigned               gap_left;
      play_mode_type             mode;
      bit                        quiet_sel;
      int                        errors;
      int                        checked;

      function new();
         int i;
         for (i = 0; i < LUT_SIZE; i++) begin
            sine_lut[i] = sine_value(i);
         end
         muted        = 1'b0;
         phase_acc    = 0;
         phase_step   = 0;
         samples_left = 0;
         gap_left     = 0;
         mode         = PLAY_IDLE;
         quiet_sel    = 1'b0;
         errors       = 0;
         checked      = 0;
      endfunction

      // Table entry: peak * sin(2*pi*i/size), Q30 Taylor series on the first quadrant.
      function int sine_value(int i);
         u64_type quadrant;
         u64_type rem;
         u64_type ang;
         u64_type ang_sq;
         u64_type term;
         u64_type mag;
         longint acc;
         int k;
         quadrant = u64_type'(i) * 4 / LUT_SIZE;
         rem      = u64_type'(i) * 4 - quadrant * LUT_SIZE;
         if (quadrant[0]) begin
            rem = LUT_SIZE - rem;
         end
         if (rem == LUT_SIZE) begin
            mag = SINE_PEAK;
         end else begin
            ang    = (64'd1686629713 * rem) / LUT_SIZE;
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            acc    = longint'(ang);
            for (k = 1; k <= 9; k++) begin
               term = ((term * ang_sq) >> 30) / u64_type'((2 * k) * (2 * k + 1));
               if (k % 2 == 1) begin
                  acc = acc - longint'(term);
               end else begin
                  acc = acc + longint'(term);
               end
            end
            if (acc < 0) begin
               acc = 0;
            end
            mag = (u64_type'(acc) * SINE_PEAK + 1024) >> 30;
            if (mag > SINE_PEAK) begin
               mag = SINE_PEAK;
            end
         end
         return (quadrant >= 2) ? -int'(mag) : int'(mag);
      endfunction

      // Advances the player state by one accepted request beat and queues its response.
      function void note_request(stbg_pkg::stbg_item_type item);
         stbg_pkg::stbg_result_type beat;
         u64_type count;
         int idx;
         int amp;
         int value;
         beat = '0;
         if (item.command == CMD_LOAD) begin
            if (mode == PLAY_IDLE && !muted) begin
               count = u64_type'(RATE_HZ) * item.burst_ms / MS_PER_S;
               beat.load_accepted = 1'b1;
               if (count != 0) begin
                  samples_left = 32'(count);
                  if (item.freq_hz == 0) begin
                     mode = PLAY_SILENCE;
                  end else begin
                     mode       = PLAY_TONE;
                     quiet_sel  = item.quiet;
                     phase_acc  = 0;
                     phase_step = ((u64_type'(item.freq_hz) * LUT_SIZE) << FRAC_BITS) / RATE_HZ;
                     phase_step = phase_step % (u64_type'(LUT_SIZE) << FRAC_BITS);
                  end
               end
            end
         end else begin
            case (mode)
               PLAY_TONE: begin
                  idx   = int'((phase_acc >> FRAC_BITS) % LUT_SIZE);
                  amp   = quiet_sel ? QUIET_AMP : SINE_PEAK;
                  value = (sine_lut[idx] * amp) / SINE_PEAK;
                  beat.sample = value[stbg_pkg::SAMPLE_W-1:0];
                  phase_acc = (phase_acc + phase_step) % (u64_type'(LUT_SIZE) << FRAC_BITS);
                  samples_left--;
                  if (samples_left == 0) begin
                     gap_left = GAP_LEN;
                     mode = (gap_left != 0) ? PLAY_GAP : PLAY_IDLE;
                  end
               end
               PLAY_SILENCE: begin
                  samples_left--;
                  if (samples_left == 0) begin
                     mode = PLAY_IDLE;
                  end
               end
               PLAY_GAP: begin
                  gap_left--;
                  if (gap_left == 0) begin
                     mode = PLAY_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
         beat.busy_res = (mode != PLAY_IDLE);
         predicted_beats.push_back(beat);
      endfunction

      task report_mismatch(string msg);
         if (errors < MAX_PRINTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
         end
         errors++;
      endtask

      // Compares one response beat with the oldest prediction.
      task check_result(stbg_pkg::stbg_result_type got);
         stbg_pkg::stbg_result_type want;
         if (predicted_beats.size() == 0) begin
            report_mismatch($sformatf("response beat %0d arrived with none predicted", checked));
            checked++;
            return;
         end
         want = predicted_beats.pop_front();
         if (got.sample !== want.sample) begin
            report_mismatch($sformatf("beat %0d: sample %0d, predicted %0d",
                                      checked, got.sample, want.sample));
         end
         if (got.busy_res !== want.busy_res) begin
            report_mismatch($sformatf("beat %0d: busy_res %b, predicted %b",
                                      checked, got.busy_res, want.busy_res));
         end
         if (got.load_accepted !== want.load_accepted) begin
            report_mismatch($sformatf("beat %0d: load_accepted %b, predicted %b",
                                      checked, got.load_accepted, want.load_accepted));
         end
         checked++;
      endtask
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic                                 req_command = CMD_TICK;
   logic [stbg_pkg::FREQ_W-1:0]          req_freq_hz = '0;
   logic [stbg_pkg::MS_W-1:0]            req_burst_ms = '0;
   logic                                 req_quiet = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [stbg_pkg::SAMPLE_W-1:0] rsp_sample;
   logic                                 rsp_busy_res;
   logic                                 rsp_load_accepted;
   logic                                 csr_write_en = 1'b0;
   logic                                 csr_write_data = 1'b0;

   tone_predictor sb = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;

   sine_tone_burst_generator uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_freq_hz       (req_freq_hz),
      .req_burst_ms      (req_burst_ms),
      .req_quiet         (req_quiet),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample        (rsp_sample),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_load_accepted (rsp_load_accepted),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic stbg_pkg::stbg_item_type pack_item(logic cmd,
                                                         logic [stbg_pkg::FREQ_W-1:0] freq,
                                                         logic [stbg_pkg::MS_W-1:0] ms,
                                                         logic q);
      stbg_pkg::stbg_item_type it;
      it.command  = cmd;
      it.freq_hz  = freq;
      it.burst_ms = ms;
      it.quiet    = q;
      return it;
   endfunction

   // Random beat shaped by the predicted player state: when a load would start something,
   // keep it short so many tones and silences fit; otherwise mostly ticks.
   function automatic stbg_pkg::stbg_item_type next_item();
      stbg_pkg::stbg_item_type it;
      it = pack_item(CMD_TICK, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     1'($urandom_range(1)));
      if (sb.mode == PLAY_IDLE && !sb.muted) begin
         if ($urandom_range(99) < 55) begin
            it.command = CMD_LOAD;
         end
         case ($urandom_range(9))
            0:       it.burst_ms = '0;
            1, 2:    it.burst_ms = 16'($urandom_range(3, 2));
            default: it.burst_ms = 16'd1;
         endcase
         if ($urandom_range(9) == 0) begin
            it.freq_hz = '0;
         end else if ($urandom_range(3) == 0) begin
            it.freq_hz = 16'($urandom_range(2000, 1));
         end
      end else if ($urandom_range(99) < 8) begin
         it.command = CMD_LOAD;
      end
      return it;
   endfunction

   // Offers one request beat after a random idle stretch and holds it until taken.
   task automatic send_item(input stbg_pkg::stbg_item_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= item.command;
      req_freq_hz  <= item.freq_hz;
      req_burst_ms <= item.burst_ms;
      req_quiet    <= item.quiet;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sb.note_request(item);
   endtask

   // Ticks until the current tone, silence or gap has finished.
   task automatic play_out();
      while (sb.mode != PLAY_IDLE) begin
         send_item(pack_item(CMD_TICK, '0, '0, 1'b0));
      end
   endtask

   // Stops offering and waits until every predicted response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.predicted_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_mute(input bit value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      sb.muted = value;
   endtask

   // Response side: check each taken beat, then choose ready for the next cycle.
   initial begin : rsp_side
      stbg_pkg::stbg_result_type got;
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.sample        = rsp_sample;
            got.busy_res      = rsp_busy_res;
            got.load_accepted = rsp_load_accepted;
            sb.check_result(got);
         end
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Request side: reset, directed cases, then the random phases.
   initial begin : req_side
      int p;
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mute(1'b0);

      // Tick while idle, with every payload bit high.
      send_item(pack_item(CMD_TICK, 16'hFFFF, 16'hFFFF, 1'b1));
      // A load whose sample count is zero is taken but starts nothing.
      send_item(pack_item(CMD_LOAD, 16'd1000, 16'd0, 1'b0));
      send_item(pack_item(CMD_TICK, '0, '0, 1'b0));
      // Silence with the quiet flag set; a load during it is refused.
      send_item(pack_item(CMD_LOAD, 16'd0, 16'd1, 1'b1));
      send_item(pack_item(CMD_LOAD, 16'hFFFF, 16'hFFFF, 1'b1));
      play_out();
      // Loads are refused while muted, even when idle.
      drain();
      write_mute(1'b1);
      send_item(pack_item(CMD_LOAD, 16'd440, 16'hFFFF, 1'b0));
      send_item(pack_item(CMD_TICK, '0, '0, 1'b0));
      drain();
      write_mute(1'b0);
      // Quarter-table steps hit both peaks and the zero crossings, at the quiet level.
      send_item(pack_item(CMD_LOAD, 16'd11025, 16'd1, 1'b1));
      play_out();
      // Highest frequency at full level; its samples and gap run on into the first phase.
      send_item(pack_item(CMD_LOAD, 16'hFFFF, 16'd1, 1'b0));

      for (p = 0; p < N_PHASES; p++) begin
         drain();
         write_mute(phase_muted[p]);
         send_idle_pct  = phase_send_idle[p];
         recv_stall_pct = phase_recv_stall[p];
         for (n = 0; n < phase_items[p]; n++) begin
            // Long receiver hold-off while beats keep coming, so the input backs up.
            if (p == 0 && n == 40) begin
               hold_request = 40;
            end
            // Sender pause until every response is back.
            if (p == 0 && n == 90) begin
               drain();
            end
            send_item(next_item());
         end
      end
      drain();

      if (sb.predicted_beats.size() != 0) begin
         sb.report_mismatch($sformatf("%0d predicted beats never arrived",
                                      sb.predicted_beats.size()));
      end
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
